// ----- rtl/core/imav_pkg.sv -----
// ----------------------------------------------------------------------------
// imav_pkg
// Shared widths, codes and types of the impedance magnitude averager.
// ----------------------------------------------------------------------------
package imav_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 48;
  localparam int MAG_FRAC           = 8;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 48;
  localparam int CNT_W  = 11;
  localparam int GAIN_W = 32;
  localparam int MAG_W  = 24;
  localparam int DEN_W  = MAG_W + GAIN_W;
  localparam int SUM_W  = 64;
  localparam int ALU_W  = DEN_W + 1;
  localparam int RAD_W  = 2 * MAG_W;
  localparam int STEP_W = 6;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [OUT_W-1:0]  OUT_MAX   = '1;
  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(1);
  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(1);

  // register word index, taken from paddr[2]
  localparam logic REG_AVG_COUNT = 1'b0;
  localparam logic REG_GAIN      = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SQRT,
    ST_MUL,
    ST_DCHK,
    ST_DIV,
    ST_ACC,
    ST_AVG,
    ST_EMIT
  } imav_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  averaging_count;
    logic [GAIN_W-1:0] gain_mantissa;
  } imav_cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] impedance_q8;
    logic             saturated;
  } imav_res_t;

endpackage

// ----- rtl/core/imav_alu.sv -----
// ----------------------------------------------------------------------------
// imav_alu
// Shared subtract and compare unit for square root and division steps.
// ----------------------------------------------------------------------------
module imav_alu (
  input  logic [imav_pkg::ALU_W-1:0] op_a,
  input  logic [imav_pkg::ALU_W-1:0] op_b,
  output logic [imav_pkg::ALU_W-1:0] diff,
  output logic                       ge
);

  logic [imav_pkg::ALU_W:0] full;

  assign full = {1'b0, op_a} - {1'b0, op_b};
  assign diff = full[imav_pkg::ALU_W-1:0];
  assign ge   = ~full[imav_pkg::ALU_W];

endmodule

// ----- rtl/core/imav_mul.sv -----
// ----------------------------------------------------------------------------
// imav_mul
// Shared unsigned multiplier for the squares and the magnitude times gain.
// ----------------------------------------------------------------------------
module imav_mul (
  input  logic [imav_pkg::MAG_W-1:0]  op_a,
  input  logic [imav_pkg::GAIN_W-1:0] op_b,
  output logic [imav_pkg::DEN_W-1:0]  prod
);

  assign prod = imav_pkg::DEN_W'(op_a) * imav_pkg::DEN_W'(op_b);

endmodule

// ----- rtl/core/imav_engine.sv -----
// ----------------------------------------------------------------------------
// imav_engine
// Sequencer and datapath: squares, root, reciprocal, sum and block average.
// ----------------------------------------------------------------------------
module imav_engine #(
  parameter int GAIN_FRAC_BITS = imav_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [imav_pkg::IN_W-1:0]  in_real_part,
  input  logic [imav_pkg::IN_W-1:0]  in_imag_part,
  input  imav_pkg::imav_cfg_t        cfg,
  output logic                       res_valid,
  input  logic                       res_take,
  output imav_pkg::imav_res_t        res
);

  localparam int K         = 2 * imav_pkg::MAG_FRAC + GAIN_FRAC_BITS;
  localparam bit K_HI      = (K >= imav_pkg::OUT_W);
  localparam int SAT_SHIFT = K_HI ? K - imav_pkg::OUT_W : 0;
  localparam int DW        = imav_pkg::DEN_W;
  localparam int SW        = imav_pkg::STEP_W;
  localparam int OW        = imav_pkg::OUT_W;
  localparam int CW        = imav_pkg::CNT_W;
  localparam int AW        = imav_pkg::ALU_W;
  localparam int MW        = imav_pkg::MAG_W;
  localparam int RW        = imav_pkg::RAD_W;
  localparam int UW        = imav_pkg::SUM_W;
  localparam int IW        = imav_pkg::IN_W;

  // 2^K >> OUT_W, the remainder that enters the low quotient bits
  localparam logic [DW-1:0] REM_INIT =
    K_HI ? ({{(DW-1){1'b0}}, 1'b1} << SAT_SHIFT) : '0;
  localparam logic [SW-1:0] K_BIT     = K_HI ? '0 : SW'(K);
  localparam logic [SW-1:0] SQRT_LAST = SW'(MW - 1);
  localparam logic [SW-1:0] DIV_LAST  = SW'(OW - 1);
  localparam logic [SW-1:0] AVG_LAST  = SW'(UW - 1);

  imav_pkg::imav_state_t state_r, state_nxt;

  logic [IW-1:0]  re_r, re_nxt, im_r, im_nxt;
  logic [RW-1:0]  rad_r, rad_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [MW-1:0]  root_r, root_nxt;
  logic [DW-1:0]  denom_r, denom_nxt;
  logic [OW-1:0]  quo_r, quo_nxt;
  logic           sat_r, sat_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [UW-1:0]  sum_r, sum_nxt;
  logic [CW-1:0]  pairs_r, pairs_nxt;
  logic           ovf_r, ovf_nxt;
  imav_pkg::imav_res_t res_r, res_nxt;

  logic [AW-1:0]  alu_a, alu_b, alu_diff;
  logic           alu_ge;
  logic [MW-1:0]  mul_a;
  logic [imav_pkg::GAIN_W-1:0] mul_b;
  logic [DW-1:0]  mul_p;

  logic [IW-1:0]  abs_re, abs_im;
  logic [CW-1:0]  count_eff;
  logic [CW-1:0]  pairs_inc;
  logic [OW-1:0]  term;
  logic [UW-1:0]  sum_acc;
  logic           ovf_any;
  logic           block_done;
  logic           dbit;
  logic           step_last;

  imav_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  imav_mul u_mul (
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign abs_re     = re_r[IW-1] ? (~re_r + IW'(1)) : re_r;
  assign abs_im     = im_r[IW-1] ? (~im_r + IW'(1)) : im_r;
  assign count_eff  = (cfg.averaging_count == '0) ? CW'(1) : cfg.averaging_count;
  assign pairs_inc  = pairs_r + CW'(1);
  assign term       = sat_r ? imav_pkg::OUT_MAX : quo_r;
  assign sum_acc    = sum_r + UW'(term);
  assign ovf_any    = ovf_r | sat_r;
  assign block_done = (pairs_inc >= count_eff);
  assign dbit       = !K_HI && (cnt_r == K_BIT);
  assign step_last  = (cnt_r == '0);

  assign in_stall  = (state_r != imav_pkg::ST_IDLE);
  assign res_valid = (state_r == imav_pkg::ST_EMIT);
  assign res       = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imav_pkg::ST_IDLE:  if (in_valid) state_nxt = imav_pkg::ST_SQ_RE;
      imav_pkg::ST_SQ_RE: state_nxt = imav_pkg::ST_SQ_IM;
      imav_pkg::ST_SQ_IM: state_nxt = imav_pkg::ST_SQRT;
      imav_pkg::ST_SQRT:  if (step_last) state_nxt = imav_pkg::ST_MUL;
      imav_pkg::ST_MUL:   state_nxt = imav_pkg::ST_DCHK;
      imav_pkg::ST_DCHK:  state_nxt = alu_ge ? imav_pkg::ST_ACC : imav_pkg::ST_DIV;
      imav_pkg::ST_DIV:   if (step_last) state_nxt = imav_pkg::ST_ACC;
      imav_pkg::ST_ACC: begin
        if (!block_done) state_nxt = imav_pkg::ST_IDLE;
        else if (ovf_any) state_nxt = imav_pkg::ST_EMIT;
        else state_nxt = imav_pkg::ST_AVG;
      end
      imav_pkg::ST_AVG:   if (step_last) state_nxt = imav_pkg::ST_EMIT;
      imav_pkg::ST_EMIT:  if (res_take) state_nxt = imav_pkg::ST_IDLE;
      default:            state_nxt = imav_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      imav_pkg::ST_SQ_RE: begin
        mul_a = MW'(abs_re);
        mul_b = imav_pkg::GAIN_W'(abs_re);
      end
      imav_pkg::ST_SQ_IM: begin
        mul_a = MW'(abs_im);
        mul_b = imav_pkg::GAIN_W'(abs_im);
      end
      imav_pkg::ST_SQRT: begin
        alu_a = AW'({rem_r[MW:0], rad_r[RW-1:RW-2]});
        alu_b = AW'({root_r, 2'b01});
      end
      imav_pkg::ST_MUL: begin
        mul_a = root_r;
        mul_b = cfg.gain_mantissa;
      end
      imav_pkg::ST_DCHK: begin
        alu_a = AW'(REM_INIT);
        alu_b = AW'(denom_r);
      end
      imav_pkg::ST_DIV: begin
        alu_a = {rem_r, dbit};
        alu_b = AW'(denom_r);
      end
      imav_pkg::ST_AVG: begin
        alu_a = AW'({rem_r[CW-1:0], sum_r[UW-1]});
        alu_b = AW'(count_eff);
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    re_nxt    = re_r;
    im_nxt    = im_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    denom_nxt = denom_r;
    quo_nxt   = quo_r;
    sat_nxt   = sat_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    pairs_nxt = pairs_r;
    ovf_nxt   = ovf_r;
    res_nxt   = res_r;
    case (state_r)
      imav_pkg::ST_IDLE: begin
        re_nxt = in_real_part;
        im_nxt = in_imag_part;
      end
      imav_pkg::ST_SQ_RE: begin
        rad_nxt = RW'(mul_p[31:0]);
      end
      imav_pkg::ST_SQ_IM: begin
        rad_nxt  = {rad_r[31:0] + mul_p[31:0], 16'h0000};
        rem_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = SQRT_LAST;
      end
      imav_pkg::ST_SQRT: begin
        rad_nxt  = rad_r << 2;
        rem_nxt  = alu_ge ? alu_diff[DW-1:0] : alu_a[DW-1:0];
        root_nxt = {root_r[MW-2:0], alu_ge};
        cnt_nxt  = cnt_r - SW'(1);
      end
      imav_pkg::ST_MUL: begin
        denom_nxt = mul_p;
      end
      imav_pkg::ST_DCHK: begin
        // quotient of 2^48 or more, or a zero divisor, saturates
        sat_nxt = alu_ge;
        rem_nxt = REM_INIT;
        quo_nxt = '0;
        cnt_nxt = DIV_LAST;
      end
      imav_pkg::ST_DIV: begin
        rem_nxt = alu_ge ? alu_diff[DW-1:0] : alu_a[DW-1:0];
        quo_nxt = {quo_r[OW-2:0], alu_ge};
        cnt_nxt = cnt_r - SW'(1);
      end
      imav_pkg::ST_ACC: begin
        if (!block_done) begin
          sum_nxt   = sum_acc;
          pairs_nxt = pairs_inc;
          ovf_nxt   = ovf_any;
        end else begin
          pairs_nxt = '0;
          ovf_nxt   = 1'b0;
          if (ovf_any) begin
            sum_nxt              = '0;
            res_nxt.impedance_q8 = imav_pkg::OUT_MAX;
            res_nxt.saturated    = 1'b1;
          end else begin
            sum_nxt = sum_acc;
            rem_nxt = '0;
            cnt_nxt = AVG_LAST;
          end
        end
      end
      imav_pkg::ST_AVG: begin
        // sum register shifts out dividend bits and takes in quotient bits
        rem_nxt = alu_ge ? alu_diff[DW-1:0] : alu_a[DW-1:0];
        sum_nxt = {sum_r[UW-2:0], alu_ge};
        cnt_nxt = cnt_r - SW'(1);
        if (step_last) begin
          res_nxt.impedance_q8 = {sum_r[OW-2:0], alu_ge};
          res_nxt.saturated    = 1'b0;
          sum_nxt              = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imav_pkg::ST_IDLE;
      sum_r   <= '0;
      pairs_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      pairs_r <= pairs_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r    <= re_nxt;
    im_r    <= im_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    denom_r <= denom_nxt;
    quo_r   <= quo_nxt;
    sat_r   <= sat_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ----- rtl/core/impedance_magnitude_averager_core.sv -----
// ----------------------------------------------------------------------------
// impedance_magnitude_averager_core
// Averages 1/(|z| * gain) over blocks of DFT result pairs.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           word
//   in_       input      in_valid/in_stall   real_part, imag_part (signed 16)
//   out_      output     out_valid/out_stall impedance_q8 (48, Q40.8), saturated
//   cfg_      APB        psel/penable        0x0 averaging_count, 0x4 gain_mantissa
//
// A word goes from acceptance to the next acceptance through two squares on the
// shared multiplier, 24 root steps and 48 reciprocal division steps on the shared
// subtractor, plus the magnitude times gain and the accumulate. A saturated term
// skips the 48 division steps. The pair that closes a block adds 64 averaging
// division steps, unless a term saturated, and a handoff to the output word.
// Reset clears the sequencer, the running sum, the pair count, the overflow
// flag and out_valid; no clearing pass. The output register frees the engine while
// out_stall holds a finished word; a second finished word waits in the engine.
// ----------------------------------------------------------------------------
module impedance_magnitude_averager_core #(
  parameter int GAIN_FRAC_BITS = imav_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [imav_pkg::IN_W-1:0]        in_real_part,
  input  logic [imav_pkg::IN_W-1:0]        in_imag_part,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [imav_pkg::OUT_W-1:0]       out_impedance_q8,
  output logic                             out_saturated,
  // register port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [imav_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [imav_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [imav_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  imav_pkg::imav_cfg_t cfg_r, cfg_nxt;
  imav_pkg::imav_res_t eng_res;
  logic                eng_res_valid;
  logic                eng_res_take;
  logic                cfg_wr;

  logic                              out_valid_r, out_valid_nxt;
  logic [imav_pkg::OUT_W-1:0]        out_q_r, out_q_nxt;
  logic                              out_sat_r, out_sat_nxt;

  // ---------------------------------------------------------------------------
  // Register port: word index sits in paddr[2]
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        imav_pkg::REG_AVG_COUNT:
          cfg_nxt.averaging_count = cfg_pwdata[imav_pkg::CNT_W-1:0];
        imav_pkg::REG_GAIN:
          cfg_nxt.gain_mantissa = cfg_pwdata[imav_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      imav_pkg::REG_AVG_COUNT:
        cfg_prdata = imav_pkg::CFG_DATA_W'(cfg_r.averaging_count);
      imav_pkg::REG_GAIN:
        cfg_prdata = imav_pkg::CFG_DATA_W'(cfg_r.gain_mantissa);
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.averaging_count <= imav_pkg::COUNT_RST;
      cfg_r.gain_mantissa   <= imav_pkg::GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequenced datapath
  // ---------------------------------------------------------------------------
  imav_engine #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_real_part (in_real_part),
    .in_imag_part (in_imag_part),
    .cfg          (cfg_r),
    .res_valid    (eng_res_valid),
    .res_take     (eng_res_take),
    .res          (eng_res)
  );

  // ---------------------------------------------------------------------------
  // Output register: take a new word when empty or when the held word leaves
  // ---------------------------------------------------------------------------
  assign eng_res_take = eng_res_valid & (~out_valid_r | ~out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_q_nxt     = out_q_r;
    out_sat_nxt   = out_sat_r;
    if (eng_res_take) begin
      out_valid_nxt = 1'b1;
      out_q_nxt     = eng_res.impedance_q8;
      out_sat_nxt   = eng_res.saturated;
    end else if (out_valid_r && !out_stall) begin
      // drop the word once it is taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_q_r   <= out_q_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_impedance_q8 = out_q_r;
  assign out_saturated    = out_sat_r;

endmodule
